// ===== rtl/double_ended_byte_queue_assert.svh =====
// Assertion macros for the deque; every use is clocked by clk and
// disabled while rst is high.
`ifndef DOUBLE_ENDED_BYTE_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_BYTE_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int OPCODE_W      = 3;
  localparam int DATA_W        = 8;
  localparam int POS_W         = 5;
  localparam int COUNT_W       = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_BACK  = 3'd4,
    OP_READ_NTH   = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS_FRONT,
    CELL_DEL_FRONT,
    CELL_WRITE,
    CELL_SNAP,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/deq_req_if.sv =====
interface deq_req_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [DATA_W-1:0]   data_in;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, data_in, position, input ready);
  modport sink   (input valid, opcode, data_in, position, output ready);
endinterface

// ===== rtl/deq_rsp_if.sv =====
interface deq_rsp_if;
  import deq_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [DATA_W-1:0]  data_out;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, ok, data_out, entry_count, input ready);
  modport sink   (input valid, ok, data_out, entry_count, output ready);
endinterface

// ===== rtl/double_ended_byte_queue.sv =====
// Channel  Dir  Payload                          Transfer
// req      in   opcode, data_in, position        req.valid && req.ready
// rsp      out  ok, data_out, entry_count        rsp.valid && rsp.ready
//
// Push front, push back, pop front, clear, failed requests: next cycle.
// Pop back, peek back and read nth: snapshot into the scan row, then the
// snapshot shifts one cell per cycle toward cell 0 along the chain.
// rst (synchronous) empties the queue; cell contents are not cleared.
// A new request is taken while a result waits, in the cycle it transfers.
module double_ended_byte_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  cell_cmd_t         cmd;
  logic [IW-1:0]     wr_idx;
  logic [DATA_W-1:0] data_row [DEPTH];
  logic [DATA_W-1:0] scan_row [DEPTH];

  deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .wr_idx    (wr_idx),
    .head_data (data_row[0]),
    .scan_data (scan_row[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data, right_data, right_scan;

    if (i == 0) begin : g_first
      assign left_data = cmd.data;
    end else begin : g_mid_l
      assign left_data = data_row[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = data_row[i];
      assign right_scan = scan_row[i];
    end else begin : g_mid_r
      assign right_data = data_row[i+1];
      assign right_scan = scan_row[i+1];
    end

    deq_cell #(.IW(IW), .IDX(IW'(i))) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .wr_idx     (wr_idx),
      .left_data  (left_data),
      .right_data (right_data),
      .right_scan (right_scan),
      .data       (data_row[i]),
      .scan       (scan_row[i])
    );
  end

endmodule

// ===== rtl/deq_cell.sv =====
module deq_cell #(
  parameter int             IW  = 4,
  parameter logic [IW-1:0]  IDX = '0
) (
  input  logic                      clk,
  input  deq_pkg::cell_cmd_t        cmd,
  input  logic [IW-1:0]             wr_idx,
  input  logic [deq_pkg::DATA_W-1:0] left_data,
  input  logic [deq_pkg::DATA_W-1:0] right_data,
  input  logic [deq_pkg::DATA_W-1:0] right_scan,
  output logic [deq_pkg::DATA_W-1:0] data,
  output logic [deq_pkg::DATA_W-1:0] scan
);
  import deq_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INS_FRONT: data <= left_data;
      CELL_DEL_FRONT: data <= right_data;
      CELL_WRITE: begin
        if (wr_idx == IDX) begin
          data <= cmd.data;
        end
      end
      CELL_SNAP: scan <= data;
      CELL_SCAN: scan <= right_scan;
      default: ;
    endcase
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
`include "double_ended_byte_queue_assert.svh"

module deq_ctrl #(
  parameter int  DEPTH = deq_pkg::DEPTH_DEFAULT,
  localparam int IW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  deq_req_if.sink                    req,
  deq_rsp_if.source                  rsp,
  output deq_pkg::cell_cmd_t         cmd,
  output logic [IW-1:0]              wr_idx,
  input  logic [deq_pkg::DATA_W-1:0] head_data,
  input  logic [deq_pkg::DATA_W-1:0] scan_data
);
  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     scan_cnt, scan_cnt_next;
  logic              scan_pop, scan_pop_next;
  logic              rsp_valid, rsp_ok;
  logic [DATA_W-1:0] rsp_data;

  logic              acc, take, full, empty, k_ok, needs_scan, is_push;
  logic              ld, ld_ok;
  logic [DATA_W-1:0] ld_data;
  logic [POS_W-1:0]  k;
  logic [IW-1:0]     last_idx, nth_idx;
  op_t               op;

  assign op        = op_t'(req.opcode);
  assign acc       = req.valid && req.ready;
  assign take      = rsp_valid && rsp.ready;
  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign k        = (req.position == '0) ? POS_W'(1) : req.position;
  assign k_ok     = (WW'(k) <= WW'(count));
  assign last_idx = IW'(count - 1'b1);
  assign nth_idx  = IW'(k - 1'b1);
  assign is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);

  assign needs_scan = (((op == OP_POP_BACK) || (op == OP_PEEK_BACK)) && !empty) ||
                      ((op == OP_READ_NTH) && k_ok);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && needs_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.data      = req.data_in;
    wr_idx        = IW'(count);
    ld            = 1'b0;
    ld_ok         = 1'b0;
    ld_data       = '0;
    count_next    = count;
    scan_cnt_next = scan_cnt;
    scan_pop_next = scan_pop;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (op)
            OP_PUSH_FRONT: begin
              ld = 1'b1;
              if (!full) begin
                cmd.op     = CELL_INS_FRONT;
                ld_ok      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              ld = 1'b1;
              if (!full) begin
                cmd.op     = CELL_WRITE;
                ld_ok      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              ld = 1'b1;
              if (!empty) begin
                cmd.op     = CELL_DEL_FRONT;
                ld_ok      = 1'b1;
                ld_data    = head_data;
                count_next = count - 1'b1;
              end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
              if (!empty) begin
                cmd.op        = CELL_SNAP;
                scan_cnt_next = last_idx;
                scan_pop_next = (op == OP_POP_BACK);
              end else begin
                ld = 1'b1;
              end
            end
            OP_READ_NTH: begin
              if (k_ok) begin
                cmd.op        = CELL_SNAP;
                scan_cnt_next = nth_idx;
                scan_pop_next = 1'b0;
              end else begin
                ld = 1'b1;
              end
            end
            OP_CLEAR: begin
              ld         = 1'b1;
              ld_ok      = 1'b1;
              count_next = '0;
            end
            default: ld = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_cnt == '0) begin
          ld      = 1'b1;
          ld_ok   = 1'b1;
          ld_data = scan_data;
          if (scan_pop) begin
            count_next = count - 1'b1;
          end
        end else begin
          cmd.op        = CELL_SCAN;
          scan_cnt_next = scan_cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (ld) begin
        rsp_valid <= 1'b1;
      end else if (take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt <= scan_cnt_next;
    scan_pop <= scan_pop_next;
    if (ld) begin
      rsp_ok   <= ld_ok;
      rsp_data <= ld_data;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.data_out    = rsp_data;
  assign rsp.entry_count = COUNT_W'(count);

  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_scan_no_rsp, state == ST_SCAN, !rsp_valid && !req.ready)
  `DEQ_ASSERT_NEXT(a_push_grows, acc && is_push && !full, count == $past(count) + 1'b1)
  `DEQ_ASSERT_NEXT(a_clear_empties, acc && op == OP_CLEAR, count == '0 && rsp_valid && rsp_ok)

endmodule
